[src/itp_pkg.sv]
// Shared types, character codes and helper functions for the infix to postfix converter.
`timescale 1ns / 1ps
`default_nettype none

package itp_pkg;

  localparam int unsigned STACK_DEPTH = 16;

  localparam logic [7:0] CH_POW  = 8'h5E;
  localparam logic [7:0] CH_MUL  = 8'h2A;
  localparam logic [7:0] CH_DIV  = 8'h2F;
  localparam logic [7:0] CH_MOD  = 8'h25;
  localparam logic [7:0] CH_ADD  = 8'h2B;
  localparam logic [7:0] CH_SUB  = 8'h2D;
  localparam logic [7:0] CH_LPAR = 8'h28;
  localparam logic [7:0] CH_RPAR = 8'h29;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  typedef enum logic [2:0] {
    CLS_END   = 3'd0,
    CLS_OPND  = 3'd1,
    CLS_LPAR  = 3'd2,
    CLS_RPAR  = 3'd3,
    CLS_OPER  = 3'd4,
    CLS_OTHER = 3'd5
  } cls_e;

  typedef enum logic [1:0] {
    EMIT_NONE = 2'd0,
    EMIT_TOP  = 2'd1,
    EMIT_CHAR = 2'd2,
    EMIT_TERM = 2'd3
  } emit_sel_e;

  typedef struct packed {
    logic      load_item;
    logic      push;
    logic      pop;
    emit_sel_e emit_sel;
    logic      emit_last;
  } ctrl_cmd_t;

  typedef struct packed {
    cls_e cls;
    logic count_zero;
    logic count_one;
    logic top_is_lpar;
    logic top_pop;
    logic next_pop;
    logic next_is_lpar;
    logic out_free;
  } dp_status_t;

  function automatic logic [1:0] rank_of(input logic [7:0] ch);
    logic [1:0] r;
    r = 2'd0;
    if (ch == CH_POW) begin
      r = 2'd3;
    end else if (ch == CH_MUL || ch == CH_DIV || ch == CH_MOD) begin
      r = 2'd2;
    end else if (ch == CH_ADD || ch == CH_SUB) begin
      r = 2'd1;
    end
    return r;
  endfunction

  function automatic logic is_operand(input logic [7:0] ch);
    return (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A) ||
           (ch >= 8'h30 && ch <= 8'h39);
  endfunction

  // True when the stacked operator must leave before the incoming one is pushed.
  function automatic logic pops_before(input logic [7:0] top, input logic [7:0] ch);
    logic [1:0] tr;
    logic [1:0] r;
    tr = rank_of(top);
    r  = rank_of(ch);
    return (tr != 2'd0) && ((tr > r) || ((tr == r) && (ch != CH_POW)));
  endfunction

endpackage

`default_nettype wire

[src/itp_if.sv]
// Valid/ready channel interfaces for input characters and postfix results.
`timescale 1ns / 1ps
`default_nettype none

interface itp_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] character;

  modport source (output valid, output opcode, output character, input ready);
  modport sink (input valid, input opcode, input character, output ready);
endinterface

interface itp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] token;
  logic       is_terminator;
  logic       run_last;
  logic       overflow;

  modport source (output valid, output token, output is_terminator, output run_last,
                  output overflow, input ready);
  modport sink (input valid, input token, input is_terminator, input run_last,
                input overflow, output ready);
endinterface

`default_nettype wire

[src/infix_to_postfix_converter_core.sv]
// Top level of the infix to postfix converter: controller and datapath.
// Each item is taken in the idle state and then evaluated; an operand goes to the output
// register from its evaluation. Each popped operator passes through a wait state before the
// next evaluation, but the pop that empties the stack on a closing parenthesis goes to idle.
// Items are handled one at a time, as the registered stack read must refresh after every pop;
// a full output register stalls them. Reset clears the count, overflow, state and output valid.
`timescale 1ns / 1ps
`default_nettype none

module infix_to_postfix_converter_core #(
  parameter int unsigned StackDepth = itp_pkg::STACK_DEPTH
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  itp_in_if.sink     in_i,
  itp_out_if.source  out_o
);

  itp_pkg::ctrl_cmd_t  cmd;
  itp_pkg::dp_status_t status;
  logic                in_ready;

  assign in_i.ready = in_ready;

  itp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  itp_dp #(
    .StackDepth (StackDepth)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .opcode_i    (in_i.opcode),
    .character_i (in_i.character),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

[src/itp_dp.sv]
// Datapath: item register, operator stack memory, stack count, overflow flag and output register.
`timescale 1ns / 1ps
`default_nettype none

module itp_dp #(
  parameter int unsigned StackDepth = itp_pkg::STACK_DEPTH
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   opcode_i,
  input  wire logic [7:0]             character_i,
  input  wire itp_pkg::ctrl_cmd_t     cmd_i,
  output      itp_pkg::dp_status_t    status_o,
  itp_out_if.source                   out_o
);

  localparam int unsigned CntW = $clog2(StackDepth + 1);
  localparam int unsigned IdxW = $clog2(StackDepth);

  logic [7:0]      stack_mem [StackDepth];
  logic            op_q;
  logic [7:0]      ch_q;
  logic [7:0]      top_q;
  logic [7:0]      rd_q;
  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      tok_q;
  logic            term_q;
  logic            last_q;
  logic            oflag_q;
  logic            full;
  logic            emit;
  logic [CntW-1:0] rd_cnt;
  logic [IdxW-1:0] rd_addr;
  itp_pkg::cls_e   cls;

  assign full    = (count_q == CntW'(StackDepth));
  assign emit    = (cmd_i.emit_sel != itp_pkg::EMIT_NONE);
  assign rd_cnt  = count_q - CntW'(2);
  assign rd_addr = rd_cnt[IdxW-1:0];

  always_comb begin
    if (op_q == itp_pkg::OP_END) begin
      cls = itp_pkg::CLS_END;
    end else if (itp_pkg::is_operand(ch_q)) begin
      cls = itp_pkg::CLS_OPND;
    end else if (ch_q == itp_pkg::CH_LPAR) begin
      cls = itp_pkg::CLS_LPAR;
    end else if (ch_q == itp_pkg::CH_RPAR) begin
      cls = itp_pkg::CLS_RPAR;
    end else if (itp_pkg::rank_of(ch_q) != 2'd0) begin
      cls = itp_pkg::CLS_OPER;
    end else begin
      cls = itp_pkg::CLS_OTHER;
    end
  end

  always_comb begin
    status_o.cls          = cls;
    status_o.count_zero   = (count_q == '0);
    status_o.count_one    = (count_q == CntW'(1));
    status_o.top_is_lpar  = (top_q == itp_pkg::CH_LPAR);
    status_o.top_pop      = itp_pkg::pops_before(top_q, ch_q);
    status_o.next_pop     = itp_pkg::pops_before(rd_q, ch_q);
    status_o.next_is_lpar = (rd_q == itp_pkg::CH_LPAR);
    status_o.out_free     = !out_valid_q || out_o.ready;
  end

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (cmd_i.push) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else if (cmd_i.pop) begin
      count_d = count_q - CntW'(1);
    end
    if (cmd_i.emit_sel == itp_pkg::EMIT_TERM) begin
      ovf_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The stack keeps its top in a register; the entry below it is read every cycle.
  always_ff @(posedge clk_i) begin
    rd_q <= stack_mem[rd_addr];
    if (cmd_i.push && !full) begin
      stack_mem[count_q[IdxW-1:0]] <= ch_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q <= opcode_i;
      ch_q <= character_i;
    end
    if (cmd_i.push && !full) begin
      top_q <= ch_q;
    end else if (cmd_i.pop) begin
      top_q <= rd_q;
    end
    if (emit) begin
      last_q <= cmd_i.emit_last;
      unique case (cmd_i.emit_sel)
        itp_pkg::EMIT_TOP: begin
          tok_q   <= top_q;
          term_q  <= 1'b0;
          oflag_q <= 1'b0;
        end
        itp_pkg::EMIT_CHAR: begin
          tok_q   <= ch_q;
          term_q  <= 1'b0;
          oflag_q <= 1'b0;
        end
        default: begin
          tok_q   <= 8'h00;
          term_q  <= 1'b1;
          oflag_q <= ovf_q;
        end
      endcase
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.token         = tok_q;
  assign out_o.is_terminator = term_q;
  assign out_o.run_last      = last_q;
  assign out_o.overflow      = oflag_q;

endmodule

`default_nettype wire

[src/itp_ctrl.sv]
// Controller state machine that sequences pushes, pops and result transfers for each item.
`timescale 1ns / 1ps
`default_nettype none

module itp_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire itp_pkg::dp_status_t status_i,
  output      itp_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_WAIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '{load_item: 1'b0, push: 1'b0, pop: 1'b0,
                emit_sel: itp_pkg::EMIT_NONE, emit_last: 1'b0};
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_EVAL;
        end
      end
      S_EVAL: begin
        unique case (status_i.cls)
          itp_pkg::CLS_END: begin
            if (status_i.out_free) begin
              if (!status_i.count_zero) begin
                cmd_o.emit_sel = itp_pkg::EMIT_TOP;
                cmd_o.pop      = 1'b1;
                state_d        = S_WAIT;
              end else begin
                cmd_o.emit_sel  = itp_pkg::EMIT_TERM;
                cmd_o.emit_last = 1'b1;
                state_d         = S_IDLE;
              end
            end
          end
          itp_pkg::CLS_OPND: begin
            if (status_i.out_free) begin
              cmd_o.emit_sel  = itp_pkg::EMIT_CHAR;
              cmd_o.emit_last = 1'b1;
              state_d         = S_IDLE;
            end
          end
          itp_pkg::CLS_LPAR: begin
            cmd_o.push = 1'b1;
            state_d    = S_IDLE;
          end
          itp_pkg::CLS_RPAR: begin
            if (status_i.count_zero) begin
              state_d = S_IDLE;
            end else if (status_i.top_is_lpar) begin
              cmd_o.pop = 1'b1;
              state_d   = S_IDLE;
            end else if (status_i.out_free) begin
              cmd_o.emit_sel  = itp_pkg::EMIT_TOP;
              cmd_o.pop       = 1'b1;
              cmd_o.emit_last = status_i.count_one || status_i.next_is_lpar;
              state_d         = status_i.count_one ? S_IDLE : S_WAIT;
            end
          end
          itp_pkg::CLS_OPER: begin
            if (!status_i.count_zero && status_i.top_pop) begin
              if (status_i.out_free) begin
                cmd_o.emit_sel  = itp_pkg::EMIT_TOP;
                cmd_o.pop       = 1'b1;
                cmd_o.emit_last = status_i.count_one || !status_i.next_pop;
                state_d         = S_WAIT;
              end
            end else begin
              cmd_o.push = 1'b1;
              state_d    = S_IDLE;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_WAIT: begin
        state_d = S_EVAL;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire
